### rtl/spsp_pkg.sv
`default_nettype none
package spsp_pkg;

  localparam int unsigned SIZE_W = 15;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW = 2;

  localparam logic [5:0] HEVC_SPS_TYPE = 6'd33;
  localparam logic [4:0] AVC_SPS_TYPE = 5'd7;
  localparam logic [4:0] MAX_ZEROS = 5'd30;
  localparam logic [31:0] MAX_MB = 32'd1023;
  localparam logic [31:0] MAX_CYCLE = 32'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              size_valid;
    logic [SIZE_W-1:0] picture_width;
    logic [SIZE_W-1:0] picture_height;
  } out_item_t;

  typedef enum logic [1:0] {
    EV_BYTE,
    EV_START,
    EV_FIN
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
  } ev_t;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_SKIP,
    PH_HDR2,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_BITS,
    MD_FIN1,
    MD_FIN2
  } mode_t;

  typedef enum logic [5:0] {
    S_H_VPS, S_H_LAYERS, S_H_NEST, S_H_PTL0, S_H_PTL1, S_H_PTL2, S_H_SUBFP,
    S_H_SUBFL, S_H_RESV, S_H_SUBP0, S_H_SUBP1, S_H_SUBP2, S_H_SUBL, S_H_SPSID,
    S_H_CHROMA, S_H_SEP, S_H_W, S_H_H,
    S_A_PROFILE, S_A_CONSTR, S_A_SPSID, S_A_CHROMA, S_A_SEP, S_A_BDL, S_A_BDC,
    S_A_QP, S_A_SMP, S_A_SLP, S_A_DELTA, S_A_FRAMENUM, S_A_POC, S_A_POCLSB,
    S_A_P1FLAG, S_A_P1A, S_A_P1B, S_A_P1N, S_A_P1OFF, S_A_REFS, S_A_GAPS,
    S_A_WM, S_A_HM, S_A_FRAME, S_A_MBAFF, S_A_D8,
    S_CROPF, S_CROP
  } step_t;

  // bit length of fixed-width fields, zero for exp-golomb fields
  function automatic logic [5:0] fixed_len(input step_t s);
    logic [5:0] n;
    case (s) inside
      S_H_VPS: n = 6'd4;
      S_H_LAYERS: n = 6'd3;
      S_H_PTL0, S_H_PTL1, S_H_PTL2, S_H_SUBP0, S_H_SUBP1: n = 6'd32;
      S_H_SUBP2: n = 6'd24;
      S_H_RESV: n = 6'd2;
      S_H_SUBL, S_A_PROFILE: n = 6'd8;
      S_A_CONSTR: n = 6'd16;
      S_H_NEST, S_H_SUBFP, S_H_SUBFL, S_H_SEP, S_A_SEP, S_A_QP, S_A_SMP, S_A_SLP,
      S_A_P1FLAG, S_A_GAPS, S_A_FRAME, S_A_MBAFF, S_A_D8, S_CROPF: n = 6'd1;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

### rtl/spsp_front.sv
`default_nettype none
module spsp_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  spsp_pkg::in_item_t  in_data,
  output logic                q_push,
  output spsp_pkg::ev_t       q_ev,
  input  wire                 q_full
);

  logic [7:0] lb_r [3];
  logic [7:0] lb_nxt [3];
  logic [1:0] fill_r, fill_nxt;
  logic       flush_r, flush_nxt;
  logic       acc;

  always_comb begin
    in_ready = !flush_r && !q_full;
    acc = in_valid && in_ready;
    lb_nxt = lb_r;
    fill_nxt = fill_r;
    flush_nxt = flush_r;
    q_push = 1'b0;
    q_ev.kind = spsp_pkg::EV_BYTE;
    q_ev.data = lb_r[0];
    if (acc) begin
      if (fill_r == 2'd3) begin
        q_push = 1'b1;
        if (lb_r[0] == 8'd0 && lb_r[1] == 8'd0 && lb_r[2] == 8'd0 &&
            in_data.data_byte == 8'd1) begin
          q_ev.kind = spsp_pkg::EV_START;
          fill_nxt = 2'd0;
        end else begin
          lb_nxt[0] = lb_r[1];
          lb_nxt[1] = lb_r[2];
          lb_nxt[2] = in_data.data_byte;
        end
      end else begin
        lb_nxt[fill_r] = in_data.data_byte;
        fill_nxt = fill_r + 2'd1;
      end
      if (in_data.last_byte) flush_nxt = 1'b1;
    end else if (flush_r && !q_full) begin
      // drain the held-back bytes, then mark the end of the stream
      q_push = 1'b1;
      if (fill_r != 2'd0) begin
        lb_nxt[0] = lb_r[1];
        lb_nxt[1] = lb_r[2];
        fill_nxt = fill_r - 2'd1;
      end else begin
        q_ev.kind = spsp_pkg::EV_FIN;
        flush_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      flush_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      flush_r <= flush_nxt;
    end
    lb_r <= lb_nxt;
  end

endmodule
`default_nettype wire

### rtl/spsp_queue.sv
`default_nettype none
module spsp_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  spsp_pkg::ev_t       push_ev,
  output logic                full,
  input  wire                 pop,
  output logic                pop_valid,
  output spsp_pkg::ev_t       pop_ev
);

  spsp_pkg::ev_t mem_r [spsp_pkg::Q_DEPTH];
  logic [spsp_pkg::Q_AW-1:0] wp_r, rp_r;
  logic [spsp_pkg::Q_AW:0]   cnt_r;
  logic                      do_push, do_pop;

  always_comb begin
    full = (cnt_r == (spsp_pkg::Q_AW+1)'(spsp_pkg::Q_DEPTH));
    pop_valid = (cnt_r != '0);
    pop_ev = mem_r[rp_r];
    do_push = push && !full;
    do_pop = pop && pop_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
    if (do_push) mem_r[wp_r] <= push_ev;
  end

endmodule
`default_nettype wire

### rtl/spsp_back.sv
`default_nettype none
module spsp_back #(
  parameter int unsigned MAX_SIDE = 16384
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  codec_hevc,
  input  wire                  ev_valid,
  input  spsp_pkg::ev_t        ev,
  output logic                 ev_pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output spsp_pkg::out_item_t  out_data
);

  spsp_pkg::mode_t  mode_r, mode_nxt;
  spsp_pkg::phase_t phase_r, phase_nxt;
  spsp_pkg::step_t  step_r, step_nxt, go_s;
  logic [1:0]  zero_run_r, zero_run_nxt;
  logic [7:0]  sr_r, sr_nxt;
  logic [2:0]  bcnt_r, bcnt_nxt;
  logic [4:0]  gzc_r, gzc_nxt;
  logic [31:0] fv_r, fv_nxt;
  logic [7:0]  lc0_r, lc0_nxt, lc1_r, lc1_nxt;
  logic [5:0]  lc2_r, lc2_nxt;
  logic [15:0] lf_r, lf_nxt;
  logic [7:0]  sl_r, sl_nxt;
  logic [1:0]  chroma_r, chroma_nxt;
  logic        sep_r, sep_nxt, frame_r, frame_nxt, hevc_r, hevc_nxt, high_r, high_nxt;
  logic [31:0] cw_r, cw_nxt, ch_r, ch_nxt;
  logic [31:0] crop_r [4];
  logic [31:0] crop_nxt [4];
  logic        err_r, err_nxt, done_r, done_nxt, suffix_r, suffix_nxt;
  logic [33:0] crx_r, crx_nxt;
  logic [34:0] cry_r, cry_nxt;
  logic        okp_r, okp_nxt;
  logic        out_valid_r, out_valid_nxt;
  spsp_pkg::out_item_t out_r, out_nxt;

  logic        go_f, fail_f, feed_en, fbit, fire, clr, ok, isfix;
  logic [31:0] sh, v, gmask;
  logic [7:0]  i1, nx, d8;
  logic [3:0]  sub_start;
  logic        hit, hit_p;
  logic [2:0]  hit_idx;
  logic [1:0]  arr;
  logic [32:0] sum_x, sum_y;
  logic [1:0]  cys;

  // next sub-layer that carries a profile or level, in the range [start, count)
  always_comb begin
    sub_start = (step_r == spsp_pkg::S_H_RESV) ? 4'd0 : ({1'b0, lc0_r[2:0]} + 4'd1);
    hit = 1'b0;
    hit_p = 1'b0;
    hit_idx = 3'd0;
    for (int j = 0; j < 8; j++) begin
      if (!hit && 4'(j) >= sub_start && 8'(j) < lc1_r && (lf_r[j] || lf_r[8+j])) begin
        hit = 1'b1;
        hit_idx = 3'(j);
        hit_p = lf_r[j];
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r; phase_nxt = phase_r; step_nxt = step_r;
    zero_run_nxt = zero_run_r; sr_nxt = sr_r; bcnt_nxt = bcnt_r;
    gzc_nxt = gzc_r; fv_nxt = fv_r; lc0_nxt = lc0_r; lc1_nxt = lc1_r; lc2_nxt = lc2_r;
    lf_nxt = lf_r; sl_nxt = sl_r; chroma_nxt = chroma_r; sep_nxt = sep_r;
    frame_nxt = frame_r; hevc_nxt = hevc_r; high_nxt = high_r;
    cw_nxt = cw_r; ch_nxt = ch_r; crop_nxt = crop_r;
    err_nxt = err_r; done_nxt = done_r; suffix_nxt = suffix_r;
    crx_nxt = crx_r; cry_nxt = cry_r; okp_nxt = okp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    ev_pop = 1'b0; go_f = 1'b0; go_s = step_r; fail_f = 1'b0;
    feed_en = 1'b0; fbit = sr_r[7]; fire = 1'b0; clr = 1'b0; ok = 1'b0;
    i1 = lc0_r + 8'd1;
    arr = sep_r ? 2'd0 : chroma_r;
    sum_x = {1'b0, crop_r[0]} + {1'b0, crop_r[1]};
    sum_y = {1'b0, crop_r[2]} + {1'b0, crop_r[3]};
    cys = {1'b0, arr == 2'd1} + {1'b0, !(hevc_r || frame_r)};

    unique case (mode_r)
      spsp_pkg::MD_IDLE: begin
        if (ev_valid) begin
          ev_pop = 1'b1;
          case (ev.kind)
            spsp_pkg::EV_BYTE: begin
              case (phase_r)
                spsp_pkg::PH_HEADER: begin
                  if (codec_hevc ? (ev.data[6:1] == spsp_pkg::HEVC_SPS_TYPE)
                                 : (ev.data[4:0] == spsp_pkg::AVC_SPS_TYPE)) begin
                    if (codec_hevc) hevc_nxt = 1'b1;
                    zero_run_nxt = 2'd0;
                    go_f = 1'b1;
                    go_s = codec_hevc ? spsp_pkg::S_H_VPS : spsp_pkg::S_A_PROFILE;
                    phase_nxt = codec_hevc ? spsp_pkg::PH_HDR2 : spsp_pkg::PH_BODY;
                  end else begin
                    phase_nxt = spsp_pkg::PH_SKIP;
                  end
                end
                spsp_pkg::PH_HDR2: phase_nxt = spsp_pkg::PH_BODY;
                spsp_pkg::PH_BODY: begin
                  // emulation prevention byte after two zeros is dropped
                  if (zero_run_r == 2'd2 && ev.data == 8'd3) begin
                    zero_run_nxt = 2'd0;
                  end else begin
                    if (ev.data == 8'd0) begin
                      zero_run_nxt = (zero_run_r == 2'd3) ? 2'd3 : zero_run_r + 2'd1;
                    end else begin
                      zero_run_nxt = 2'd0;
                    end
                    sr_nxt = ev.data;
                    bcnt_nxt = 3'd0;
                    mode_nxt = spsp_pkg::MD_BITS;
                  end
                end
                default: ;
              endcase
            end
            spsp_pkg::EV_START: begin
              if (phase_r == spsp_pkg::PH_HDR2 || phase_r == spsp_pkg::PH_BODY) begin
                if (!done_r) fail_f = 1'b1;
                phase_nxt = spsp_pkg::PH_DONE;
              end else if (phase_r != spsp_pkg::PH_DONE) begin
                phase_nxt = spsp_pkg::PH_HEADER;
              end
            end
            spsp_pkg::EV_FIN: begin
              if ((phase_r == spsp_pkg::PH_HDR2 || phase_r == spsp_pkg::PH_BODY) && !done_r)
                fail_f = 1'b1;
              mode_nxt = spsp_pkg::MD_FIN1;
            end
            default: ;
          endcase
        end
      end
      spsp_pkg::MD_BITS: begin
        feed_en = 1'b1;
        sr_nxt = {sr_r[6:0], 1'b0};
        bcnt_nxt = bcnt_r + 3'd1;
      end
      spsp_pkg::MD_FIN1: begin
        okp_nxt = done_r && !err_r;
        crx_nxt = (arr == 2'd1 || arr == 2'd2) ? {sum_x, 1'b0} : {1'b0, sum_x};
        cry_nxt = {2'b00, sum_y} << cys;
        mode_nxt = spsp_pkg::MD_FIN2;
      end
      spsp_pkg::MD_FIN2: begin
        if (!out_valid_r || out_ready) begin
          ok = okp_r && ({2'b00, cw_r} > crx_r) && ({3'b000, ch_r} > cry_r) &&
               (cw_r <= 32'(MAX_SIDE)) && (ch_r <= 32'(MAX_SIDE));
          out_nxt.size_valid = ok;
          out_nxt.picture_width = ok ? spsp_pkg::SIZE_W'(cw_r - crx_r[31:0]) : '0;
          out_nxt.picture_height = ok ? spsp_pkg::SIZE_W'(ch_r - cry_r[31:0]) : '0;
          out_valid_nxt = 1'b1;
          clr = 1'b1;
          mode_nxt = spsp_pkg::MD_IDLE;
        end
      end
      default: mode_nxt = spsp_pkg::MD_IDLE;
    endcase

    // one payload bit through the exp-golomb / fixed-length reader
    sh = {fv_r[30:0], fbit};
    gmask = (32'd1 << gzc_r) - 32'd1;
    isfix = (spsp_pkg::fixed_len(step_r) != 6'd0);
    v = 32'd0;
    if (feed_en) begin
      if (isfix || suffix_r) begin
        fv_nxt = sh;
        lc2_nxt = lc2_r - 6'd1;
        fire = (lc2_r == 6'd1);
        v = suffix_r && !isfix ? gmask + sh : sh;
      end else if (!fbit) begin
        gzc_nxt = gzc_r + 5'd1;
        if (gzc_r >= spsp_pkg::MAX_ZEROS) fail_f = 1'b1;
      end else if (gzc_r == 5'd0) begin
        fire = 1'b1;
      end else begin
        suffix_nxt = 1'b1;
        lc2_nxt = {1'b0, gzc_r};
        fv_nxt = 32'd0;
      end
    end

    d8 = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
    nx = sl_r + d8;

    if (fire) begin
      unique case (step_r) inside
        spsp_pkg::S_H_VPS: begin go_f = 1'b1; go_s = spsp_pkg::S_H_LAYERS; end
        spsp_pkg::S_H_LAYERS: begin
          lc1_nxt = {5'd0, v[2:0]};
          go_f = 1'b1; go_s = spsp_pkg::S_H_NEST;
        end
        spsp_pkg::S_H_NEST: begin go_f = 1'b1; go_s = spsp_pkg::S_H_PTL0; end
        spsp_pkg::S_H_PTL0: begin go_f = 1'b1; go_s = spsp_pkg::S_H_PTL1; end
        spsp_pkg::S_H_PTL1: begin go_f = 1'b1; go_s = spsp_pkg::S_H_PTL2; end
        spsp_pkg::S_H_PTL2: begin
          go_f = 1'b1;
          if (lc1_r != 8'd0) begin
            lc0_nxt = 8'd0;
            go_s = spsp_pkg::S_H_SUBFP;
          end else begin
            go_s = spsp_pkg::S_H_SPSID;
          end
        end
        spsp_pkg::S_H_SUBFP: begin
          if (v[0]) lf_nxt[{1'b0, lc0_r[2:0]}] = 1'b1;
          go_f = 1'b1; go_s = spsp_pkg::S_H_SUBFL;
        end
        spsp_pkg::S_H_SUBFL: begin
          if (v[0]) lf_nxt[{1'b1, lc0_r[2:0]}] = 1'b1;
          lc0_nxt = i1;
          go_f = 1'b1;
          go_s = (i1 < lc1_r) ? spsp_pkg::S_H_SUBFP : spsp_pkg::S_H_RESV;
        end
        spsp_pkg::S_H_RESV, spsp_pkg::S_H_SUBP2, spsp_pkg::S_H_SUBL: begin
          go_f = 1'b1;
          if (step_r == spsp_pkg::S_H_RESV && i1 < 8'd8) begin
            lc0_nxt = i1;
            go_s = spsp_pkg::S_H_RESV;
          end else if (step_r == spsp_pkg::S_H_SUBP2 && lf_r[{1'b1, lc0_r[2:0]}]) begin
            go_s = spsp_pkg::S_H_SUBL;
          end else if (hit) begin
            lc0_nxt = {5'd0, hit_idx};
            go_s = hit_p ? spsp_pkg::S_H_SUBP0 : spsp_pkg::S_H_SUBL;
          end else begin
            if (step_r == spsp_pkg::S_H_RESV) lc0_nxt = i1;
            go_s = spsp_pkg::S_H_SPSID;
          end
        end
        spsp_pkg::S_H_SUBP0: begin go_f = 1'b1; go_s = spsp_pkg::S_H_SUBP1; end
        spsp_pkg::S_H_SUBP1: begin go_f = 1'b1; go_s = spsp_pkg::S_H_SUBP2; end
        spsp_pkg::S_H_SPSID: begin go_f = 1'b1; go_s = spsp_pkg::S_H_CHROMA; end
        spsp_pkg::S_H_CHROMA, spsp_pkg::S_A_CHROMA: begin
          if (v > 32'd3) begin
            fail_f = 1'b1;
          end else begin
            chroma_nxt = v[1:0];
            go_f = 1'b1;
            if (step_r == spsp_pkg::S_H_CHROMA)
              go_s = (v == 32'd3) ? spsp_pkg::S_H_SEP : spsp_pkg::S_H_W;
            else
              go_s = (v == 32'd3) ? spsp_pkg::S_A_SEP : spsp_pkg::S_A_BDL;
          end
        end
        spsp_pkg::S_H_SEP: begin
          if (v[0]) sep_nxt = 1'b1;
          go_f = 1'b1; go_s = spsp_pkg::S_H_W;
        end
        spsp_pkg::S_H_W: begin cw_nxt = v; go_f = 1'b1; go_s = spsp_pkg::S_H_H; end
        spsp_pkg::S_H_H: begin ch_nxt = v; go_f = 1'b1; go_s = spsp_pkg::S_CROPF; end
        spsp_pkg::S_A_PROFILE: begin
          // profiles that carry the chroma and scaling-list fields
          case (v[7:0]) inside
            8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118, 8'd128,
            8'd138, 8'd139, 8'd134, 8'd135: high_nxt = 1'b1;
            default: ;
          endcase
          go_f = 1'b1; go_s = spsp_pkg::S_A_CONSTR;
        end
        spsp_pkg::S_A_CONSTR: begin go_f = 1'b1; go_s = spsp_pkg::S_A_SPSID; end
        spsp_pkg::S_A_SPSID: begin
          go_f = 1'b1;
          go_s = high_r ? spsp_pkg::S_A_CHROMA : spsp_pkg::S_A_FRAMENUM;
        end
        spsp_pkg::S_A_SEP: begin
          if (v[0]) sep_nxt = 1'b1;
          go_f = 1'b1; go_s = spsp_pkg::S_A_BDL;
        end
        spsp_pkg::S_A_BDL: begin go_f = 1'b1; go_s = spsp_pkg::S_A_BDC; end
        spsp_pkg::S_A_BDC: begin go_f = 1'b1; go_s = spsp_pkg::S_A_QP; end
        spsp_pkg::S_A_QP: begin go_f = 1'b1; go_s = spsp_pkg::S_A_SMP; end
        spsp_pkg::S_A_SMP: begin
          go_f = 1'b1;
          if (v[0]) begin
            lc0_nxt = 8'd0;
            go_s = spsp_pkg::S_A_SLP;
          end else begin
            go_s = spsp_pkg::S_A_FRAMENUM;
          end
        end
        spsp_pkg::S_A_SLP, spsp_pkg::S_A_DELTA: begin
          go_f = 1'b1;
          if (step_r == spsp_pkg::S_A_SLP && v[0]) begin
            lc1_nxt = 8'd0;
            sl_nxt = 8'd8;
            go_s = spsp_pkg::S_A_DELTA;
          end else if (step_r == spsp_pkg::S_A_DELTA && nx != 8'd0 &&
                       (lc1_r + 8'd1) < ((lc0_r < 8'd6) ? 8'd16 : 8'd64)) begin
            sl_nxt = nx;
            lc1_nxt = lc1_r + 8'd1;
            go_s = spsp_pkg::S_A_DELTA;
          end else begin
            // list finished: move on to the next scaling list
            if (step_r == spsp_pkg::S_A_DELTA) begin
              lc1_nxt = lc1_r + 8'd1;
              if (nx != 8'd0) sl_nxt = nx;
            end
            lc0_nxt = i1;
            go_s = (i1 < ((chroma_r == 2'd3) ? 8'd12 : 8'd8)) ? spsp_pkg::S_A_SLP
                                                               : spsp_pkg::S_A_FRAMENUM;
          end
        end
        spsp_pkg::S_A_FRAMENUM: begin go_f = 1'b1; go_s = spsp_pkg::S_A_POC; end
        spsp_pkg::S_A_POC: begin
          go_f = (v <= 32'd2);
          fail_f = (v > 32'd2);
          if (v == 32'd0) go_s = spsp_pkg::S_A_POCLSB;
          else if (v == 32'd1) go_s = spsp_pkg::S_A_P1FLAG;
          else go_s = spsp_pkg::S_A_REFS;
        end
        spsp_pkg::S_A_POCLSB: begin go_f = 1'b1; go_s = spsp_pkg::S_A_REFS; end
        spsp_pkg::S_A_P1FLAG: begin go_f = 1'b1; go_s = spsp_pkg::S_A_P1A; end
        spsp_pkg::S_A_P1A: begin go_f = 1'b1; go_s = spsp_pkg::S_A_P1B; end
        spsp_pkg::S_A_P1B: begin go_f = 1'b1; go_s = spsp_pkg::S_A_P1N; end
        spsp_pkg::S_A_P1N: begin
          if (v > spsp_pkg::MAX_CYCLE) begin
            fail_f = 1'b1;
          end else begin
            lc1_nxt = v[7:0];
            lc0_nxt = 8'd0;
            go_f = 1'b1;
            go_s = (v != 32'd0) ? spsp_pkg::S_A_P1OFF : spsp_pkg::S_A_REFS;
          end
        end
        spsp_pkg::S_A_P1OFF: begin
          lc0_nxt = i1;
          go_f = 1'b1;
          go_s = (i1 < lc1_r) ? spsp_pkg::S_A_P1OFF : spsp_pkg::S_A_REFS;
        end
        spsp_pkg::S_A_REFS: begin go_f = 1'b1; go_s = spsp_pkg::S_A_GAPS; end
        spsp_pkg::S_A_GAPS: begin go_f = 1'b1; go_s = spsp_pkg::S_A_WM; end
        spsp_pkg::S_A_WM, spsp_pkg::S_A_HM: begin
          if (v > spsp_pkg::MAX_MB) begin
            fail_f = 1'b1;
          end else begin
            go_f = 1'b1;
            if (step_r == spsp_pkg::S_A_WM) begin
              cw_nxt = {18'd0, {1'b0, v[9:0]} + 11'd1, 3'd0} << 1;
              go_s = spsp_pkg::S_A_HM;
            end else begin
              ch_nxt = {18'd0, {1'b0, v[9:0]} + 11'd1, 3'd0} << 1;
              go_s = spsp_pkg::S_A_FRAME;
            end
          end
        end
        spsp_pkg::S_A_FRAME: begin
          frame_nxt = v[0];
          go_f = 1'b1;
          go_s = v[0] ? spsp_pkg::S_A_D8 : spsp_pkg::S_A_MBAFF;
        end
        spsp_pkg::S_A_MBAFF: begin go_f = 1'b1; go_s = spsp_pkg::S_A_D8; end
        spsp_pkg::S_A_D8: begin
          if (!frame_r) ch_nxt = {ch_r[30:0], 1'b0};
          go_f = 1'b1; go_s = spsp_pkg::S_CROPF;
        end
        spsp_pkg::S_CROPF: begin
          if (v[0]) begin
            lc0_nxt = 8'd0;
            go_f = 1'b1; go_s = spsp_pkg::S_CROP;
          end else begin
            done_nxt = 1'b1;
          end
        end
        spsp_pkg::S_CROP: begin
          crop_nxt[lc0_r[1:0]] = v;
          lc0_nxt = i1;
          if (i1 < 8'd4) begin
            go_f = 1'b1; go_s = spsp_pkg::S_CROP;
          end else begin
            done_nxt = 1'b1;
          end
        end
        default: fail_f = 1'b1;
      endcase
    end

    if (go_f) begin
      step_nxt = go_s;
      fv_nxt = 32'd0;
      gzc_nxt = 5'd0;
      suffix_nxt = 1'b0;
      lc2_nxt = spsp_pkg::fixed_len(go_s);
    end
    if (fail_f) begin
      err_nxt = 1'b1;
      done_nxt = 1'b1;
    end
    if (mode_r == spsp_pkg::MD_BITS && (done_nxt || bcnt_r == 3'd7)) begin
      mode_nxt = spsp_pkg::MD_IDLE;
      if (done_nxt) phase_nxt = spsp_pkg::PH_DONE;
    end

    if (clr) begin
      phase_nxt = spsp_pkg::PH_SEARCH; step_nxt = spsp_pkg::S_H_VPS;
      zero_run_nxt = 2'd0; gzc_nxt = 5'd0; fv_nxt = 32'd0;
      lc0_nxt = 8'd0; lc1_nxt = 8'd0; lc2_nxt = 6'd0; lf_nxt = 16'd0; sl_nxt = 8'd8;
      chroma_nxt = 2'd1; sep_nxt = 1'b0; frame_nxt = 1'b1; hevc_nxt = 1'b0;
      high_nxt = 1'b0; cw_nxt = 32'd0; ch_nxt = 32'd0;
      for (int k = 0; k < 4; k++) crop_nxt[k] = 32'd0;
      err_nxt = 1'b0; done_nxt = 1'b0; suffix_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= spsp_pkg::MD_IDLE;
      phase_r <= spsp_pkg::PH_SEARCH;
      step_r <= spsp_pkg::S_H_VPS;
      zero_run_r <= 2'd0; gzc_r <= 5'd0; fv_r <= 32'd0;
      lc0_r <= 8'd0; lc1_r <= 8'd0; lc2_r <= 6'd0; lf_r <= 16'd0; sl_r <= 8'd8;
      chroma_r <= 2'd1; sep_r <= 1'b0; frame_r <= 1'b1; hevc_r <= 1'b0; high_r <= 1'b0;
      cw_r <= 32'd0; ch_r <= 32'd0;
      for (int k = 0; k < 4; k++) crop_r[k] <= 32'd0;
      err_r <= 1'b0; done_r <= 1'b0; suffix_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; phase_r <= phase_nxt; step_r <= step_nxt;
      zero_run_r <= zero_run_nxt; gzc_r <= gzc_nxt; fv_r <= fv_nxt;
      lc0_r <= lc0_nxt; lc1_r <= lc1_nxt; lc2_r <= lc2_nxt; lf_r <= lf_nxt; sl_r <= sl_nxt;
      chroma_r <= chroma_nxt; sep_r <= sep_nxt; frame_r <= frame_nxt;
      hevc_r <= hevc_nxt; high_r <= high_nxt;
      cw_r <= cw_nxt; ch_r <= ch_nxt; crop_r <= crop_nxt;
      err_r <= err_nxt; done_r <= done_nxt; suffix_r <= suffix_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sr_r <= sr_nxt;
    bcnt_r <= bcnt_nxt;
    crx_r <= crx_nxt;
    cry_r <= cry_nxt;
    okp_r <= okp_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.size_valid) |->
      (out_r.picture_width == '0 && out_r.picture_height == '0))
    else $error("invalid result with nonzero size");

  a_bits_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == spsp_pkg::MD_BITS) |-> (phase_r == spsp_pkg::PH_BODY && !done_r))
    else $error("bit reader active outside an open sps body");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.size_valid) |->
      ({17'd0, out_r.picture_width} <= 32'(MAX_SIDE) &&
       {17'd0, out_r.picture_height} <= 32'(MAX_SIDE)))
    else $error("valid size above the side limit");

  a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> ($past(mode_r) == spsp_pkg::MD_FIN2))
    else $error("result produced outside the finish step");

endmodule
`default_nettype wire

### rtl/sps_picture_size_parser_top.sv
// channel  | handshake            | payload
// in       | in_valid / in_ready  | in_data   (data_byte, last_byte)
// out      | out_valid / out_ready| out_data  (size_valid, picture_width, picture_height)
// cfg      | cfg_we               | cfg_wdata (codec_hevc)
// bytes outside the sps body are consumed in the back end's idle mode; a body byte is
// shifted through the bit-serial exp-golomb reader (one payload bit per cycle)
// the last item adds up to four queue entries, then the finish steps FIN1 and FIN2 give the result
// a four-entry item queue decouples the byte front end from the bit reader
// rst_n is synchronous; the result register holds under out_ready low
`default_nettype none
module sps_picture_size_parser_top #(
  parameter int unsigned MAX_SIDE = 16384
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  spsp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output spsp_pkg::out_item_t  out_data,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata
);

  logic          codec_hevc_r;
  logic          q_push, q_full, q_pop, q_valid;
  spsp_pkg::ev_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) codec_hevc_r <= 1'b0;
    else if (cfg_we) codec_hevc_r <= cfg_wdata;
  end

  spsp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_push(q_push), .q_ev(q_in), .q_full(q_full)
  );

  spsp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_ev(q_in), .full(q_full),
    .pop(q_pop), .pop_valid(q_valid), .pop_ev(q_out)
  );

  spsp_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk(clk), .rst_n(rst_n), .codec_hevc(codec_hevc_r),
    .ev_valid(q_valid), .ev(q_out), .ev_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire
